>>> rtl/core/qpc_pkg.sv
// ----------------------------------------------------------------------------
// qpc_pkg
// Shared types and constants of the quadrature position counter.
// ----------------------------------------------------------------------------
package qpc_pkg;

  // Request kinds
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Read channels
  localparam logic [1:0] CH_RAW = 2'd0;
  localparam logic [1:0] CH_REV = 2'd1;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNSUP = 1'b1;

  // Register indexes (taken from paddr[2])
  localparam logic REG_PPR = 1'b0;
  localparam logic REG_SPP = 1'b1;
  localparam int   PADDR_W = 3;

  // Field widths
  localparam int COUNT_W = 32;
  localparam int FRAC_W  = 21;
  localparam int PPR_W   = 16;
  localparam int SPP_W   = 3;
  localparam int RES_W   = PPR_W + SPP_W;   // resolution = ppr * spp
  localparam int FQ_W    = 20;              // fraction magnitude, < 1000000
  localparam int PROD_W  = RES_W + FQ_W;    // remainder * 1000000

  // Shared divider: dividend width and step counter width
  localparam int DIV_BITS  = 40;
  localparam int DIV_CNT_W = 6;

  localparam logic [FQ_W-1:0] FRAC_SCALE = 20'd1000000;

  // Queued read request: count snapshot plus channel
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [1:0]         channel;
  } qpc_entry_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WHOLE,
    ST_MUL,
    ST_FSTART,
    ST_FRAC,
    ST_DONE
  } qpc_state_t;

endpackage

>>> rtl/core/qpc_front.sv
// ----------------------------------------------------------------------------
// qpc_front
// Accepts words, counts edge events and queues read requests with a
// snapshot of the position count.
// ----------------------------------------------------------------------------
module qpc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic                        in_edge_phase,
  input  logic                        in_other_level,
  input  logic [1:0]                  in_channel,
  input  logic                        q_full,
  output logic                        q_push,
  output qpc_pkg::qpc_entry_t         q_wdata,
  output logic [qpc_pkg::COUNT_W-1:0] count
);
  import qpc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               edge_acc;

  // Edge events never wait; reads wait for queue space
  assign in_ready = !q_full || (in_req_type == REQ_EDGE);
  assign edge_acc = in_valid && in_ready && (in_req_type == REQ_EDGE);
  assign q_push   = in_valid && !q_full && (in_req_type == REQ_READ);

  // Advance up when the rising phase matches the other level, else down
  always_comb begin
    count_nxt = count_r;
    if (edge_acc) begin
      if (in_edge_phase == in_other_level) begin
        count_nxt = count_r + 32'd1;
      end else begin
        count_nxt = count_r - 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign q_wdata.count   = count_r;
  assign q_wdata.channel = in_channel;
  assign count           = count_r;

endmodule

>>> rtl/core/qpc_queue.sv
// ----------------------------------------------------------------------------
// qpc_queue
// Short FIFO of read requests between the front and back ends.
// ----------------------------------------------------------------------------
module qpc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qpc_pkg::qpc_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                rvalid,
  output qpc_pkg::qpc_entry_t rdata
);
  import qpc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  qpc_entry_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign rvalid  = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;
  assign rdata   = mem_r[rd_ptr_r];

  // Hold the stored words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/qpc_div.sv
// ----------------------------------------------------------------------------
// qpc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [qpc_pkg::DIV_BITS-1:0] dividend,
  input  logic [qpc_pkg::RES_W-1:0]    divisor,
  output logic                         done,
  output logic [qpc_pkg::DIV_BITS-1:0] quotient,
  output logic [qpc_pkg::RES_W-1:0]    remainder
);
  import qpc_pkg::*;

  logic [DIV_BITS-1:0]  dvd_r;
  logic [RES_W-1:0]     rem_r;
  logic [RES_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [RES_W:0]       trial;
  logic [RES_W:0]       diff;
  logic                 ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem_r, dvd_r[DIV_BITS-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as dividend bits move out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DIV_BITS-2:0], ge};
      rem_r <= ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

>>> rtl/core/qpc_back.sv
// ----------------------------------------------------------------------------
// qpc_back
// Serves queued read requests: raw count, revolutions with fraction, or
// unsupported status, into a registered result stage.
// ----------------------------------------------------------------------------
module qpc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  qpc_pkg::qpc_entry_t          q_entry,
  output logic                         q_pop,
  input  logic [qpc_pkg::PPR_W-1:0]    ppr,
  input  logic [qpc_pkg::SPP_W-1:0]    spp,
  output logic                         div_start,
  output logic [qpc_pkg::DIV_BITS-1:0] div_dividend,
  output logic [qpc_pkg::RES_W-1:0]    div_divisor,
  input  logic                         div_done,
  input  logic [qpc_pkg::DIV_BITS-1:0] div_quot,
  input  logic [qpc_pkg::RES_W-1:0]    div_rem,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [qpc_pkg::COUNT_W-1:0] out_whole_value,
  output logic signed [qpc_pkg::FRAC_W-1:0]  out_fraction_value,
  output logic                         out_status
);
  import qpc_pkg::*;

  qpc_state_t         state_r;
  qpc_state_t         state_nxt;
  logic               neg_r;
  logic [COUNT_W-1:0] whole_q_r;
  logic [RES_W-1:0]   rem_q_r;
  logic [PROD_W-1:0]  prod_r;
  logic [FQ_W-1:0]    frac_q_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_whole_r;
  logic [FRAC_W-1:0]  out_frac_r;
  logic               out_status_r;

  logic               slot_free;
  logic               is_rev;
  logic [COUNT_W-1:0] mag;
  logic [RES_W-1:0]   res_prod;
  logic               out_load;
  logic [COUNT_W-1:0] load_whole;
  logic [FRAC_W-1:0]  load_frac;
  logic               load_status;

  assign slot_free = !out_valid_r || out_ready;
  assign is_rev    = (q_entry.channel == CH_REV);
  assign mag       = q_entry.count[COUNT_W-1] ? (~q_entry.count + 32'd1) : q_entry.count;

  // Resolution, a zero product reads as one
  always_comb begin
    res_prod = RES_W'(ppr) * RES_W'(spp);
    div_divisor = (res_prod == '0) ? RES_W'(1) : res_prod;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && is_rev) begin
          state_nxt = ST_WHOLE;
        end
      end
      ST_WHOLE: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:    state_nxt = ST_FSTART;
      ST_FSTART: state_nxt = ST_FRAC;
      ST_FRAC: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = {8'b0, mag};
    out_load     = 1'b0;
    load_whole   = '0;
    load_frac    = '0;
    load_status  = STATUS_OK;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && is_rev) begin
          q_pop     = 1'b1;
          div_start = 1'b1;
        end else if (q_valid && slot_free) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          if (q_entry.channel == CH_RAW) begin
            load_whole = q_entry.count;
          end else begin
            load_status = STATUS_UNSUP;
          end
        end
      end
      ST_FSTART: begin
        div_start    = 1'b1;
        div_dividend = DIV_BITS'(prod_r);
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          load_whole = neg_r ? (~whole_q_r + 32'd1) : whole_q_r;
          load_frac  = neg_r ? (~{1'b0, frac_q_r} + 21'd1) : {1'b0, frac_q_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture sign, quotients and the scaled remainder
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && div_start) begin
      neg_r <= q_entry.count[COUNT_W-1];
    end
    if (state_r == ST_WHOLE && div_done) begin
      whole_q_r <= div_quot[COUNT_W-1:0];
      rem_q_r   <= div_rem;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(rem_q_r) * PROD_W'(FRAC_SCALE);
    end
    if (state_r == ST_FRAC && div_done) begin
      frac_q_r <= div_quot[FQ_W-1:0];
    end
    if (out_load) begin
      out_whole_r  <= load_whole;
      out_frac_r   <= load_frac;
      out_status_r <= load_status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_whole_value    = out_whole_r;
  assign out_fraction_value = out_frac_r;
  assign out_status         = out_status_r;

endmodule

>>> rtl/core/quadrature_position_counter.sv
// ----------------------------------------------------------------------------
// quadrature_position_counter
// Quadrature edge counter with raw and revolution reads.
// Input words (in_valid/in_ready) are edge events or read requests. An edge
// event moves the 32-bit wrapping count by one and is taken every cycle,
// even while reads are pending. A read snapshots the count and joins a
// QUEUE_DEPTH-entry queue; it gives one result word (out_valid/out_ready).
// Raw and unsupported reads pass from the queue into the result register. A
// revolution read runs the one-bit-per-cycle 40-step divider twice (whole
// revolutions, then millionths); reads are served one at a time. A stalled
// receiver holds the result register; the queue then fills and in_ready
// drops for reads only. Synchronous reset clears the count and sets both
// registers to 1. APB registers: 0x0 pulses per rev, 0x4 steps per pulse.
// ----------------------------------------------------------------------------
module quadrature_position_counter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic                               in_edge_phase,
  input  logic                               in_other_level,
  input  logic [1:0]                         in_channel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qpc_pkg::COUNT_W-1:0] out_whole_value,
  output logic signed [qpc_pkg::FRAC_W-1:0]  out_fraction_value,
  output logic                               out_status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qpc_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import qpc_pkg::*;

  logic [PPR_W-1:0]    ppr_r;
  logic [SPP_W-1:0]    spp_r;
  logic                cfg_wr;
  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  qpc_entry_t          q_wdata;
  qpc_entry_t          q_rdata;
  logic [COUNT_W-1:0]  pos_count;
  logic                div_start;
  logic [DIV_BITS-1:0] div_dividend;
  logic [RES_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIV_BITS-1:0] div_quot;
  logic [RES_W-1:0]    div_rem;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= PPR_W'(1);
      spp_r <= SPP_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PPR) begin
        ppr_r <= pwdata[PPR_W-1:0];
      end else begin
        spp_r <= pwdata[SPP_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SPP) ? {29'b0, spp_r} : {16'b0, ppr_r};

  qpc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_edge_phase  (in_edge_phase),
    .in_other_level (in_other_level),
    .in_channel     (in_channel),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .count          (pos_count)
  );

  qpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  qpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  qpc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (q_rdata),
    .q_pop              (q_pop),
    .ppr                (ppr_r),
    .spp                (spp_r),
    .div_start          (div_start),
    .div_dividend       (div_dividend),
    .div_divisor        (div_divisor),
    .div_done           (div_done),
    .div_quot           (div_quot),
    .div_rem            (div_rem),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_whole_value    (out_whole_value),
    .out_fraction_value (out_fraction_value),
    .out_status         (out_status)
  );

`ifndef SYNTHESIS
  // Each accepted edge event moves the count by exactly one
  a_edge_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == REQ_EDGE)) |=>
      ((pos_count == $past(pos_count) + 32'd1) ||
       (pos_count == $past(pos_count) - 32'd1)))
    else $error("edge event did not move the count by one");

  // The count holds when no edge event is taken
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && (in_req_type == REQ_EDGE)) |=> $stable(pos_count))
    else $error("count changed without an edge event");

  // An unsupported status carries zero values
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_UNSUP)) |->
      ((out_whole_value == '0) && (out_fraction_value == '0)))
    else $error("unsupported result with non-zero value");
`endif

endmodule
